// ===== rtl/core/dat_pkg.sv =====
// Shared types, codes and default sizes for the disk access timing model.
// No dependencies; every file in rtl/core except dat_ram imports this package.
package dat_pkg;

  // Default geometry and timing
  localparam int DEF_TRACK_COUNT       = 4;
  localparam int DEF_SECTORS_PER_TRACK = 5;
  localparam int DEF_STEP_TIME_MS      = 2;

  // Fixed field widths
  localparam int OP_W   = 2;
  localparam int ADDR_W = 5;
  localparam int WORD_W = 32;
  localparam int ADDR_SPAN = 1 << ADDR_W;

  // Operation codes (code 3 is unused and does nothing)
  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Command word
  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [ADDR_W-1:0]        sector_address;
    logic signed [WORD_W-1:0] write_value;
  } cmd_t;

  // Response word
  typedef struct packed {
    logic signed [WORD_W-1:0] read_data;
    logic [WORD_W-1:0]        total_latency;
    logic                     bad_address;
  } rsp_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEEK,
    ST_COST,
    ST_COMMIT
  } dat_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic seek;
    logic cost;
    logic commit;
  } dat_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic access;
  } dat_status_t;

endpackage

// ===== rtl/core/disk_access_timing_model_unit.sv =====
// Top level of the disk access timing model: controller plus datapath.
// Depends on dat_pkg, dat_ctrl, dat_datapath (and dat_ram below it).
//
//   channel  | handshake            | word
//   ---------+----------------------+------------------------------------
//   command  | cmd_valid, cmd_ready | cmd (op, sector_address, write_value)
//   response | rsp_valid, rsp_ready | rsp (read_data, total_latency, bad_address)
//
// A read or write in range passes through load, seek, cost and commit before the next
// accept; clear, unused codes and bad addresses skip the cost step.
// The response sits in an output register, so a new word is accepted while the
// previous response waits; commit stalls only if that register is still full.
// Reset (rst, synchronous) zeroes head, platter, latency total and the store's valid bits.
module disk_access_timing_model_unit import dat_pkg::*; #(
  parameter int TRACK_COUNT       = DEF_TRACK_COUNT,
  parameter int SECTORS_PER_TRACK = DEF_SECTORS_PER_TRACK,
  parameter int STEP_TIME_MS      = DEF_STEP_TIME_MS
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  dat_cmd_t    ctl;
  dat_status_t status;

  // Sequencer
  dat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .ctl       (ctl)
  );

  // Timing and storage
  dat_datapath #(
    .TRACK_COUNT       (TRACK_COUNT),
    .SECTORS_PER_TRACK (SECTORS_PER_TRACK),
    .STEP_TIME_MS      (STEP_TIME_MS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .ctl    (ctl),
    .status (status),
    .rsp    (rsp)
  );

endmodule

// ===== rtl/core/dat_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/dat_ctrl.sv =====
// Sequencer for one disk access: load, seek, cost, commit; owns response valid.
// Depends on dat_pkg.
module dat_ctrl import dat_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  input  dat_status_t status,
  output dat_cmd_t    ctl
);

  dat_state_t state, state_next;
  logic       rsp_valid_next;

  // State and response-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next     = state;
    ctl            = '0;
    cmd_ready      = 1'b0;
    rsp_valid_next = rsp_valid && !rsp_ready;
    unique case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          ctl.load   = 1'b1;
          state_next = ST_SEEK;
        end
      end
      ST_SEEK: begin
        // skip timing for clear, no-op and bad addresses
        if (status.access) begin
          ctl.seek   = 1'b1;
          state_next = ST_COST;
        end else begin
          state_next = ST_COMMIT;
        end
      end
      ST_COST: begin
        ctl.cost   = 1'b1;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the output register is free
        if (!rsp_valid || rsp_ready) begin
          ctl.commit     = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/dat_datapath.sv =====
// Datapath: address split, seek and rotation timing, latency total, sector store.
// Depends on dat_pkg and dat_ram.
module dat_datapath import dat_pkg::*; #(
  parameter int TRACK_COUNT       = DEF_TRACK_COUNT,
  parameter int SECTORS_PER_TRACK = DEF_SECTORS_PER_TRACK,
  parameter int STEP_TIME_MS      = DEF_STEP_TIME_MS
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  dat_cmd_t    ctl,
  output dat_status_t status,
  output rsp_t        rsp
);

  localparam int SECTOR_COUNT = TRACK_COUNT * SECTORS_PER_TRACK;
  localparam int STORE_DEPTH  = (SECTOR_COUNT < ADDR_SPAN) ? SECTOR_COUNT : ADDR_SPAN;
  localparam int SA_W   = $clog2(STORE_DEPTH);
  localparam int TRK_W  = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
  localparam int POS_W  = $clog2(SECTORS_PER_TRACK);
  localparam int SUM_W  = ((TRK_W > POS_W) ? TRK_W : POS_W) + 1;
  localparam int STEP_W = 8;
  localparam int COST_W = SUM_W + STEP_W;
  localparam int LIM_W  = $clog2(SECTOR_COUNT + 1);
  localparam int CNT_W  = (LIM_W > ADDR_W) ? LIM_W : ADDR_W;
  localparam logic [CNT_W-1:0]  SECTOR_LIMIT = CNT_W'(SECTOR_COUNT);
  localparam logic [POS_W:0]    SPT_V        = (POS_W + 1)'(SECTORS_PER_TRACK);
  localparam logic [STEP_W-1:0] STEP_V       = STEP_W'(STEP_TIME_MS);

  // Constant tables: track and position of each address, distance mod sectors
  logic [TRK_W-1:0] trk_tab  [ADDR_SPAN];
  logic [POS_W-1:0] pos_tab  [ADDR_SPAN];
  logic [POS_W-1:0] dmod_tab [1 << TRK_W];

  for (genvar i = 0; i < ADDR_SPAN; i++) begin : g_split
    assign trk_tab[i] = TRK_W'(i / SECTORS_PER_TRACK);
    assign pos_tab[i] = POS_W'(i % SECTORS_PER_TRACK);
  end
  for (genvar i = 0; i < (1 << TRK_W); i++) begin : g_dmod
    assign dmod_tab[i] = POS_W'(i % SECTORS_PER_TRACK);
  end

  // Captured item
  logic [OP_W-1:0]   op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [WORD_W-1:0] wval_q;
  logic [TRK_W-1:0]  trk_q;
  logic [POS_W-1:0]  pos_q;
  logic              access_q;
  logic              bad_q;

  // Timing pipeline
  logic [TRK_W-1:0]  dist_q;
  logic [POS_W-1:0]  plat_q;
  logic [COST_W-1:0] cost_q;

  // Architectural state
  logic [TRK_W-1:0]       head_track;
  logic [POS_W-1:0]       platter_position;
  logic [WORD_W-1:0]      latency_total;
  logic [STORE_DEPTH-1:0] sector_valid;

  logic              is_rw, addr_bad;
  logic [TRK_W-1:0]  seek_dist;
  logic [POS_W:0]    plat_sum, plat;
  logic [POS_W:0]    wait_cnt;
  logic [SUM_W-1:0]  steps;
  logic [WORD_W:0]   lat_sum;
  logic [WORD_W-1:0] latency_total_next;
  logic [POS_W:0]    pos_inc;
  logic [POS_W-1:0]  platter_next;
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] read_word;
  logic              ram_we;

  // Decode at load
  assign is_rw    = (cmd.op == OP_READ) || (cmd.op == OP_WRITE);
  assign addr_bad = CNT_W'(cmd.sector_address) >= SECTOR_LIMIT;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_q     <= cmd.op;
      addr_q   <= cmd.sector_address;
      wval_q   <= cmd.write_value;
      trk_q    <= trk_tab[cmd.sector_address];
      pos_q    <= pos_tab[cmd.sector_address];
      access_q <= is_rw && !addr_bad;
      bad_q    <= is_rw && addr_bad;
    end
  end

  assign status.access = access_q;

  // Seek: distance and platter position on arrival
  assign seek_dist = (trk_q > head_track) ? (trk_q - head_track) : (head_track - trk_q);
  assign plat_sum  = {1'b0, platter_position} + {1'b0, dmod_tab[seek_dist]};
  assign plat      = (plat_sum >= SPT_V) ? (plat_sum - SPT_V) : plat_sum;

  always_ff @(posedge clk) begin
    if (ctl.seek) begin
      dist_q <= seek_dist;
      plat_q <= plat[POS_W-1:0];
    end
  end

  // Cost: rotational wait, then steps times step time
  assign wait_cnt = (pos_q >= plat_q) ? ({1'b0, pos_q} - {1'b0, plat_q})
                                      : ({1'b0, pos_q} + SPT_V - {1'b0, plat_q});
  assign steps    = SUM_W'(dist_q) + SUM_W'(wait_cnt) + SUM_W'(1);

  always_ff @(posedge clk) begin
    if (ctl.cost) begin
      cost_q <= COST_W'(steps) * COST_W'(STEP_V);
    end
  end

  // Commit: saturating total, head and platter update
  assign lat_sum = {1'b0, latency_total} + (WORD_W + 1)'(cost_q);
  assign pos_inc = {1'b0, pos_q} + (POS_W + 1)'(1);
  assign platter_next = (pos_inc == SPT_V) ? '0 : pos_inc[POS_W-1:0];

  always_comb begin
    latency_total_next = latency_total;
    priority if (op_q == OP_CLEAR) begin
      latency_total_next = '0;
    end else if (access_q) begin
      latency_total_next = lat_sum[WORD_W] ? '1 : lat_sum[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_track       <= '0;
      platter_position <= '0;
      latency_total    <= '0;
      sector_valid     <= '0;
    end else if (ctl.commit) begin
      latency_total <= latency_total_next;
      if (access_q) begin
        head_track       <= trk_q;
        platter_position <= platter_next;
      end
      if (ram_we) begin
        sector_valid[addr_q[SA_W-1:0]] <= 1'b1;
      end
    end
  end

  // Sector store; unwritten entries read as zero
  assign ram_we = ctl.commit && access_q && (op_q == OP_WRITE);

  dat_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_q[SA_W-1:0]),
    .wdata (wval_q),
    .re    (ctl.load),
    .raddr (cmd.sector_address[SA_W-1:0]),
    .rdata (ram_rdata)
  );

  assign read_word = (access_q && (op_q == OP_READ) && sector_valid[addr_q[SA_W-1:0]])
                     ? ram_rdata : '0;

  // Output register
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      rsp.read_data     <= read_word;
      rsp.total_latency <= latency_total_next;
      rsp.bad_address   <= bad_q;
    end
  end

endmodule

// ===== rtl/core/dat_checker.sv =====
// Port-level checks for disk_access_timing_model_unit, bound to the top level.
// Depends on dat_pkg.
module dat_checker import dat_pkg::*; (
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  logic [1:0] pending;
  logic       cmd_fire, rsp_fire;

  assign cmd_fire = cmd_valid && cmd_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  // Count words accepted but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (cmd_fire && !rsp_fire) begin
      pending <= pending + 2'd1;
    end else if (rsp_fire && !cmd_fire) begin
      pending <= pending - 2'd1;
    end
  end

  // Response holds while stalled
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // No response without an accepted command
  a_rsp_cause: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("response with no command outstanding");

  // At most one word in flight besides a waiting response
  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    cmd_ready |-> pending <= 2'd1)
    else $error("command accepted while one is still in process");

  // A flagged address never returns data
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.bad_address |-> rsp.read_data == '0)
    else $error("bad address returned data");

endmodule

bind disk_access_timing_model_unit dat_checker u_dat_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for disk_access_timing_model_unit: random and directed
// command words, with a latency/store predictor that checks every response word.
// Depends on dat_pkg and the RTL under rtl/core.
module testbench import dat_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SECTOR_COUNT = DEF_TRACK_COUNT * DEF_SECTORS_PER_TRACK;
  localparam int PER_TRACK    = DEF_SECTORS_PER_TRACK;
  localparam int STEP_MS      = DEF_STEP_TIME_MS;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;

  // Predict head, platter, latency and sector words; hold expected responses
  class disk_latency_book;
    int           head_trk;
    int           platter_pos;
    logic [31:0]  latency_ms;
    logic [31:0]  sector_words [SECTOR_COUNT];
    rsp_t         due_responses [$];
    int           mismatches;

    function new();
      head_trk    = 0;
      platter_pos = 0;
      latency_ms  = '0;
      mismatches  = 0;
      foreach (sector_words[i]) sector_words[i] = '0;
    endfunction

    // Apply one accepted command word and queue its response
    function void log_access(cmd_t c);
      rsp_t        want;
      int          trk;
      int          pos;
      int          seek_trk;
      int          plat;
      int          wait_n;
      logic [63:0] sum;
      want = '0;
      if (c.op == OP_CLEAR) begin
        latency_ms = '0;
      end else if (c.op == OP_READ || c.op == OP_WRITE) begin
        if (int'(c.sector_address) >= SECTOR_COUNT) begin
          want.bad_address = 1'b1;
        end else begin
          trk      = int'(c.sector_address) / PER_TRACK;
          pos      = int'(c.sector_address) % PER_TRACK;
          seek_trk = (trk > head_trk) ? trk - head_trk : head_trk - trk;
          plat     = (platter_pos + seek_trk) % PER_TRACK;
          wait_n   = (pos + PER_TRACK - plat) % PER_TRACK;
          sum      = {32'd0, latency_ms} + 64'((seek_trk + wait_n + 1) * STEP_MS);
          // saturate the running total
          latency_ms  = (sum > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
          head_trk    = trk;
          platter_pos = (pos + 1) % PER_TRACK;
          if (c.op == OP_READ) want.read_data = sector_words[c.sector_address];
          else sector_words[c.sector_address] = c.write_value;
        end
      end
      want.total_latency = latency_ms;
      due_responses.push_back(want);
    endfunction

    // Compare one accepted response word with the oldest expectation
    function void compare_response(rsp_t got);
      rsp_t want;
      if (due_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: response with none pending: data %h latency %0d bad %b",
                   $realtime, got.read_data, got.total_latency, got.bad_address);
        return;
      end
      want = due_responses.pop_front();
      if (got.read_data !== want.read_data || got.total_latency !== want.total_latency ||
          got.bad_address !== want.bad_address) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: response mismatch: data %h/%h latency %0d/%0d bad %b/%b (exp/got)",
                   $realtime, want.read_data, got.read_data, want.total_latency,
                   got.total_latency, want.bad_address, got.bad_address);
      end
    endfunction

    function int pending();
      return due_responses.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  disk_latency_book book = new();
  int valid_idle_pct = 6;
  int ready_idle_pct = 53;
  int stall_left     = 0;
  int cycle_count    = 0;

  disk_access_timing_model_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: abort the run well past the slowest legal finish
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[disk_access_timing_model_unit] ERROR");
      $finish;
    end
  end

  // Sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst && cmd_valid && cmd_ready) book.log_access(cmd);
    if (!rst && rsp_valid && rsp_ready) book.compare_response(rsp);
  end

  // Drive ready: hold off while a stall is counting down, else idle at random
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp_ready = 1'b0;
        stall_left--;
      end else begin
        rsp_ready = ($urandom_range(99) >= ready_idle_pct);
      end
    end
  end

  function automatic cmd_t make_word(logic [OP_W-1:0] op, int addr, logic [31:0] value);
    cmd_t c;
    c.op             = op;
    c.sector_address = addr[ADDR_W-1:0];
    c.write_value    = value;
    return c;
  endfunction

  // Build a random command word, mostly in-range reads and writes
  function automatic cmd_t random_word();
    logic [OP_W-1:0] op;
    int              r;
    int              addr;
    logic [31:0]     value;
    r = $urandom_range(99);
    if (r < 44) op = OP_READ;
    else if (r < 88) op = OP_WRITE;
    else if (r < 94) op = OP_CLEAR;
    else op = OP_UNUSED;
    addr = ($urandom_range(99) < 85) ? $urandom_range(SECTOR_COUNT - 1) : $urandom_range(31);
    case ($urandom_range(19))
      0: value = 32'h7FFF_FFFF;
      1: value = 32'h8000_0000;
      2: value = 32'hFFFF_FFFF;
      3: value = 32'h0000_0000;
      default: value = $urandom;
    endcase
    return make_word(op, addr, value);
  endfunction

  // Offer one word after an optional random gap; return once it is accepted
  task automatic send_word(input cmd_t c);
    while ($urandom_range(99) < valid_idle_pct) begin
      cmd_valid = 1'b0;
      @(negedge clk);
    end
    cmd_valid = 1'b1;
    cmd       = c;
    do @(posedge clk); while (!cmd_ready);
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_word(random_word());
  endtask

  // Hold the sender until every expected response has arrived
  task automatic drain_responses();
    cmd_valid = 1'b0;
    while (book.pending() != 0) @(negedge clk);
  endtask

  initial begin
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: fresh reads, long seeks, word extremes, bad addresses, clear, unused code
    send_word(make_word(OP_READ,   0,  32'h0));
    send_word(make_word(OP_WRITE,  19, 32'h7FFF_FFFF));
    send_word(make_word(OP_WRITE,  0,  32'h8000_0000));
    send_word(make_word(OP_READ,   19, 32'h0));
    send_word(make_word(OP_READ,   0,  32'hFFFF_FFFF));
    send_word(make_word(OP_WRITE,  4,  32'hFFFF_FFFF));
    send_word(make_word(OP_WRITE,  5,  32'h0));
    send_word(make_word(OP_READ,   4,  32'h0));
    send_word(make_word(OP_READ,   20, 32'h0));
    send_word(make_word(OP_WRITE,  31, 32'hFFFF_FFFF));
    send_word(make_word(OP_READ,   31, 32'h0));
    send_word(make_word(OP_UNUSED, 7,  32'h1234_5678));
    send_word(make_word(OP_CLEAR,  31, 32'hFFFF_FFFF));
    send_word(make_word(OP_WRITE,  10, 32'h5555_5555));
    send_word(make_word(OP_WRITE,  15, 32'hAAAA_AAAA));
    send_word(make_word(OP_READ,   10, 32'h0));
    send_word(make_word(OP_READ,   15, 32'h0));
    send_word(make_word(OP_READ,   5,  32'h0));
    send_word(make_word(OP_READ,   6,  32'h0));
    send_word(make_word(OP_UNUSED, 0,  32'h0));
    send_word(make_word(OP_CLEAR,  0,  32'h0));
    send_word(make_word(OP_READ,   3,  32'h0));

    // Random, receiver mostly stalling
    send_random(480);

    // Random, sender mostly idle
    valid_idle_pct = 53;
    ready_idle_pct = 6;
    send_random(480);

    // Random, no idling; first fill the block behind a long receiver hold-off
    valid_idle_pct = 0;
    ready_idle_pct = 0;
    stall_left     = 300;
    send_random(60);
    drain_responses();
    repeat (4) @(negedge clk);
    send_random(410);

    drain_responses();
    repeat (16) @(posedge clk);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("[disk_access_timing_model_unit] OK");
    end else begin
      $display("[disk_access_timing_model_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/dat_pkg.sv
rtl/core/dat_ram.sv
rtl/core/dat_ctrl.sv
rtl/core/dat_datapath.sv
rtl/core/disk_access_timing_model_unit.sv
rtl/core/dat_checker.sv
tb/testbench.sv
